FILE: rtl/gtl_pkg.sv
// Shared types, constants and helper functions of the GBK text layout engine.
`default_nettype none
package gtl_pkg;

	// Parameter defaults
	localparam int COORD_BITS_DEF      = 16;
	localparam int FLASH_ADDR_BITS_DEF = 24;

	// Fixed field widths
	localparam int COORD_FIELD_W = 16;
	localparam int ADDR_FIELD_W  = 24;
	localparam int CFG_DATA_W    = 24;
	localparam int CFG_IDX_W     = 3;
	// Compare width: 16-bit coordinate plus 16-bit extent, no overflow
	localparam int CMP_W         = COORD_FIELD_W + 2;
	// Linear glyph index 190*126+189 fits in 15 bits
	localparam int IDX_W         = 15;
	// Index times glyph bytes fits in 21 bits
	localparam int PROD_W        = 21;
	// Product plus 24-bit base
	localparam int SUM_W         = ADDR_FIELD_W + 1;
	localparam int MASK_W        = 33;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BASE  = 3'd5;

	// Register reset values
	localparam logic [15:0] AREA_WIDTH_RST  = 16'd240;
	localparam logic [15:0] AREA_HEIGHT_RST = 16'd320;
	localparam logic [1:0]  FONT_SIZE_RST   = 2'd1;

	// Font size selector codes
	localparam logic [1:0] FONT_12 = 2'd0;
	localparam logic [1:0] FONT_16 = 2'd1;
	localparam logic [1:0] FONT_24 = 2'd2;

	// Text byte codes
	localparam logic [7:0] BYTE_NUL     = 8'h00;
	localparam logic [7:0] BYTE_LF      = 8'h0A;
	localparam logic [7:0] BYTE_CR      = 8'h0D;
	localparam logic [7:0] ASCII_TOP    = 8'h80;
	localparam logic [7:0] LEAD_MIN     = 8'h81;
	localparam logic [7:0] TRAIL_MIN    = 8'h40;
	localparam logic [7:0] TRAIL_GAP    = 8'h7F;
	localparam logic [7:0] TRAIL_SHIFT  = 8'h41;
	localparam logic [7:0] CODE_INVALID = 8'hFF;
	localparam logic [7:0] ROW_CODES    = 8'd190;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ASCII = 2'd0,
		KIND_WIDE  = 2'd1,
		KIND_CLIP  = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	// Byte class decided in the wrap cycle
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_TERM,
		CLS_WIDE,
		CLS_ASCII,
		CLS_NEWLINE
	} cls_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRAP,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic wrap;
		logic emit;
	} gtl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic has_result;
		logic out_busy;
	} gtl_sts_t;

	// Glyph height in pixels
	function automatic logic [4:0] font_px(input logic [1:0] sel);
		logic [4:0] px;
		unique case (sel)
			FONT_12: px = 5'd12;
			FONT_16: px = 5'd16;
			default: px = 5'd24;
		endcase
		return px;
	endfunction

	// Bytes per wide glyph bitmap
	function automatic logic [6:0] glyph_bytes(input logic [1:0] sel);
		logic [6:0] nb;
		unique case (sel)
			FONT_12: nb = 7'd24;
			FONT_16: nb = 7'd32;
			default: nb = 7'd72;
		endcase
		return nb;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/gtl_ctrl.sv
// Controller state machine: accept, wrap and emit sequencing.
`default_nettype none
module gtl_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire gtl_pkg::gtl_sts_t sts,
	output gtl_pkg::gtl_cmd_t     cmd
);

	gtl_pkg::state_t state_q, state_d;
	logic            blocked;

	// Result waits when the output register is still held
	assign blocked = sts.has_result && sts.out_busy;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gtl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = gtl_pkg::ST_WRAP;
				end
			end
			gtl_pkg::ST_WRAP: begin
				state_d = gtl_pkg::ST_EMIT;
			end
			gtl_pkg::ST_EMIT: begin
				if (!blocked) begin
					state_d = in_valid ? gtl_pkg::ST_WRAP : gtl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gtl_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		unique case (state_q)
			gtl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			gtl_pkg::ST_WRAP: begin
				cmd.wrap = 1'b1;
			end
			gtl_pkg::ST_EMIT: begin
				cmd.emit = !blocked;
				in_stall = blocked;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		cmd.load = in_valid && !in_stall;
	end

endmodule
`default_nettype wire

FILE: rtl/gtl_dp.sv
// Datapath: config registers, cursor, glyph address and result register.
`default_nettype none
module gtl_dp #(
	parameter int COORD_BITS      = gtl_pkg::COORD_BITS_DEF,
	parameter int FLASH_ADDR_BITS = gtl_pkg::FLASH_ADDR_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gtl_pkg::gtl_cmd_t                    cmd,
	output gtl_pkg::gtl_sts_t                         sts,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [gtl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [gtl_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic [7:0]                           text_byte,
	input  wire logic                                 first_of_string,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [1:0]                                result_kind,
	output logic [gtl_pkg::COORD_FIELD_W-1:0]         pos_x,
	output logic [gtl_pkg::COORD_FIELD_W-1:0]         pos_y,
	output logic [6:0]                                ascii_code,
	output logic [gtl_pkg::ADDR_FIELD_W-1:0]          glyph_address,
	output logic                                      blank_glyph
);

	localparam int CW = gtl_pkg::CMP_W;

	// Config registers
	logic [15:0] origin_x_q, origin_y_q, area_width_q, area_height_q;
	logic [1:0]  font_size_q;
	logic [23:0] glyph_base_q;

	// Layout state
	logic [COORD_BITS-1:0] cursor_x_q, cursor_y_q;
	logic                  lead_pending_q, stopped_q;
	logic [7:0]            lead_byte_q;

	// Accepted byte
	logic [7:0] byte_q;
	logic       first_q;

	// Wrap-cycle results
	gtl_pkg::cls_t             cls_q, cls_d;
	logic [gtl_pkg::IDX_W-1:0] idx_q;
	logic                      blank_q;

	// Output register
	logic                               out_valid_q;
	gtl_pkg::kind_t                     kind_q;
	logic [gtl_pkg::COORD_FIELD_W-1:0]  pos_x_q, pos_y_q;
	logic [6:0]                         ascii_q;
	logic [gtl_pkg::ADDR_FIELD_W-1:0]   addr_q;
	logic                               oblank_q;

	// Common signals
	logic [4:0]            px;
	logic [3:0]            half_px;
	logic [6:0]            gbytes;
	logic [COORD_BITS-1:0] ox, oy;

	assign px      = gtl_pkg::font_px(font_size_q);
	assign half_px = px[4:1];
	assign gbytes  = gtl_pkg::glyph_bytes(font_size_q);
	assign ox      = origin_x_q[COORD_BITS-1:0];
	assign oy      = origin_y_q[COORD_BITS-1:0];

	// Wrap cycle: apply string start, classify, wrap the cursor
	logic                  stopped_eff, lead_eff;
	logic [COORD_BITS-1:0] cx_eff, cy_eff, cx_wrap, cy_wrap;
	logic [4:0]            gw;
	logic                  do_wrap;
	logic                  blank_d;
	logic [6:0]            row;
	logic [7:0]            col;
	logic [gtl_pkg::IDX_W-1:0] idx_d;

	assign stopped_eff = first_q ? 1'b0 : stopped_q;
	assign lead_eff    = first_q ? 1'b0 : lead_pending_q;
	assign cx_eff      = first_q ? ox : cursor_x_q;
	assign cy_eff      = first_q ? oy : cursor_y_q;

	always_comb begin
		priority if (stopped_eff) begin
			cls_d = gtl_pkg::CLS_NONE;
		end else if (byte_q == gtl_pkg::BYTE_NUL) begin
			cls_d = gtl_pkg::CLS_TERM;
		end else if (lead_eff) begin
			cls_d = gtl_pkg::CLS_WIDE;
		end else if (byte_q > gtl_pkg::ASCII_TOP) begin
			cls_d = gtl_pkg::CLS_NONE;
		end else if (byte_q == gtl_pkg::BYTE_LF || byte_q == gtl_pkg::BYTE_CR) begin
			cls_d = gtl_pkg::CLS_NEWLINE;
		end else begin
			cls_d = gtl_pkg::CLS_ASCII;
		end
	end

	// Wrap when cursor + glyph width passes origin + width
	assign gw      = (cls_d == gtl_pkg::CLS_WIDE) ? px : {1'b0, half_px};
	assign do_wrap = (CW'(cx_eff) + CW'(gw)) > (CW'(ox) + CW'(area_width_q));
	assign cx_wrap = do_wrap ? ox : cx_eff;
	assign cy_wrap = do_wrap ? (cy_eff + COORD_BITS'(px)) : cy_eff;

	// Linear glyph index from lead and trail
	always_comb begin
		blank_d = (lead_byte_q < gtl_pkg::LEAD_MIN) || (byte_q < gtl_pkg::TRAIL_MIN) ||
			(byte_q == gtl_pkg::CODE_INVALID) || (lead_byte_q == gtl_pkg::CODE_INVALID);
		row     = 7'(lead_byte_q - gtl_pkg::LEAD_MIN);
		col     = (byte_q < gtl_pkg::TRAIL_GAP) ? (byte_q - gtl_pkg::TRAIL_MIN)
			: (byte_q - gtl_pkg::TRAIL_SHIFT);
		idx_d   = gtl_pkg::IDX_W'(row) * gtl_pkg::IDX_W'(gtl_pkg::ROW_CODES) +
			gtl_pkg::IDX_W'(col);
	end

	// Emit cycle: clip test and flash address
	logic                       clip;
	logic                       is_draw;
	logic [gtl_pkg::PROD_W-1:0] prod;
	logic [gtl_pkg::SUM_W-1:0]  sum;
	logic [gtl_pkg::MASK_W-1:0] sum_ext, fab_mask;
	logic [gtl_pkg::ADDR_FIELD_W-1:0] addr_d;

	assign is_draw = (cls_q == gtl_pkg::CLS_WIDE) || (cls_q == gtl_pkg::CLS_ASCII) ||
		(cls_q == gtl_pkg::CLS_NEWLINE);
	assign clip    = is_draw &&
		((CW'(cursor_y_q) + CW'(px)) > (CW'(oy) + CW'(area_height_q)));
	assign prod     = gtl_pkg::PROD_W'(idx_q) * gtl_pkg::PROD_W'(gbytes);
	assign sum      = gtl_pkg::SUM_W'(prod) + gtl_pkg::SUM_W'(glyph_base_q);
	assign sum_ext  = gtl_pkg::MASK_W'(sum);
	assign fab_mask = (gtl_pkg::MASK_W'(1) << FLASH_ADDR_BITS) - gtl_pkg::MASK_W'(1);
	assign addr_d   = blank_q ? '0 : gtl_pkg::ADDR_FIELD_W'(sum_ext & fab_mask);

	assign sts.has_result = (cls_q == gtl_pkg::CLS_TERM) || (cls_q == gtl_pkg::CLS_WIDE) ||
		(cls_q == gtl_pkg::CLS_ASCII) || (cls_q == gtl_pkg::CLS_NEWLINE && clip);
	assign sts.out_busy   = out_valid_q && out_stall;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			area_width_q  <= gtl_pkg::AREA_WIDTH_RST;
			area_height_q <= gtl_pkg::AREA_HEIGHT_RST;
			font_size_q   <= gtl_pkg::FONT_SIZE_RST;
			glyph_base_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gtl_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_data[15:0];
				gtl_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_data[15:0];
				gtl_pkg::REG_AREA_WIDTH:  area_width_q  <= cfg_data[15:0];
				gtl_pkg::REG_AREA_HEIGHT: area_height_q <= cfg_data[15:0];
				gtl_pkg::REG_FONT_SIZE:   font_size_q   <= cfg_data[1:0];
				gtl_pkg::REG_GLYPH_BASE:  glyph_base_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q  <= text_byte;
			first_q <= first_of_string;
		end
	end

	// Wrap-cycle payload
	always_ff @(posedge clk) begin
		if (cmd.wrap) begin
			idx_q   <= idx_d;
			blank_q <= blank_d;
		end
	end

	// Layout state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			lead_pending_q <= 1'b0;
			lead_byte_q    <= '0;
			stopped_q      <= 1'b1;
			cls_q          <= gtl_pkg::CLS_NONE;
		end else if (cmd.wrap) begin
			cls_q          <= cls_d;
			stopped_q      <= stopped_eff;
			lead_pending_q <= lead_eff;
			if (cls_d == gtl_pkg::CLS_WIDE || cls_d == gtl_pkg::CLS_ASCII ||
				cls_d == gtl_pkg::CLS_NEWLINE) begin
				cursor_x_q <= cx_wrap;
				cursor_y_q <= cy_wrap;
			end else begin
				cursor_x_q <= cx_eff;
				cursor_y_q <= cy_eff;
			end
			if (!stopped_eff) begin
				if (cls_d == gtl_pkg::CLS_TERM || cls_d == gtl_pkg::CLS_WIDE) begin
					lead_pending_q <= 1'b0;
				end else if (cls_d == gtl_pkg::CLS_NONE) begin
					lead_pending_q <= 1'b1;
					lead_byte_q    <= byte_q;
				end
			end
		end else if (cmd.emit) begin
			priority if (cls_q == gtl_pkg::CLS_TERM || clip) begin
				stopped_q <= 1'b1;
			end else if (cls_q == gtl_pkg::CLS_WIDE) begin
				cursor_x_q <= cursor_x_q + COORD_BITS'(px);
			end else if (cls_q == gtl_pkg::CLS_ASCII) begin
				cursor_x_q <= cursor_x_q + COORD_BITS'(half_px);
			end else if (cls_q == gtl_pkg::CLS_NEWLINE) begin
				cursor_x_q <= ox;
				cursor_y_q <= cursor_y_q + COORD_BITS'(px);
			end else begin
				stopped_q <= stopped_q;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && sts.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit && sts.has_result) begin
			pos_x_q  <= gtl_pkg::COORD_FIELD_W'(cursor_x_q);
			pos_y_q  <= gtl_pkg::COORD_FIELD_W'(cursor_y_q);
			ascii_q  <= '0;
			addr_q   <= '0;
			oblank_q <= 1'b0;
			priority if (clip) begin
				kind_q <= gtl_pkg::KIND_CLIP;
			end else if (cls_q == gtl_pkg::CLS_TERM) begin
				kind_q <= gtl_pkg::KIND_END;
			end else if (cls_q == gtl_pkg::CLS_WIDE) begin
				kind_q   <= gtl_pkg::KIND_WIDE;
				addr_q   <= addr_d;
				oblank_q <= blank_q;
			end else begin
				kind_q  <= gtl_pkg::KIND_ASCII;
				ascii_q <= byte_q[6:0];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign ascii_code    = ascii_q;
	assign glyph_address = addr_q;
	assign blank_glyph   = oblank_q;

endmodule
`default_nettype wire

FILE: rtl/gbk_text_layout_engine_unit.sv
// A byte is captured when accepted, passes the wrap state, and the emit state
// then registers its result. The next byte is accepted during the emit state.
// Cursor loop: wrap, then clip and advance; the glyph multiply spans both.
// A full output register holds the emit cycle until the result is taken.
// Reset: registers take their defaults, cursor is zero, no result until a
// byte with first_of_string set.
`default_nettype none
module gbk_text_layout_engine_unit #(
	parameter int COORD_BITS      = gtl_pkg::COORD_BITS_DEF,
	parameter int FLASH_ADDR_BITS = gtl_pkg::FLASH_ADDR_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [gtl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gtl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      text_byte,
	input  wire logic                            first_of_string,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           result_kind,
	output logic [gtl_pkg::COORD_FIELD_W-1:0]    pos_x,
	output logic [gtl_pkg::COORD_FIELD_W-1:0]    pos_y,
	output logic [6:0]                           ascii_code,
	output logic [gtl_pkg::ADDR_FIELD_W-1:0]     glyph_address,
	output logic                                 blank_glyph
);

	gtl_pkg::gtl_cmd_t cmd;
	gtl_pkg::gtl_sts_t sts;

	// Sequencer
	gtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Cursor and address datapath
	gtl_dp #(
		.COORD_BITS      (COORD_BITS),
		.FLASH_ADDR_BITS (FLASH_ADDR_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.text_byte       (text_byte),
		.first_of_string (first_of_string),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.ascii_code      (ascii_code),
		.glyph_address   (glyph_address),
		.blank_glyph     (blank_glyph)
	);

endmodule
`default_nettype wire

FILE: bench/gbk_text_layout_engine_unit_tb.sv
// Self-checking bench for the GBK text layout engine: directed table, random strings, scoreboard.
module gbk_text_layout_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 3000;
	localparam int LONG_HOLD     = 400;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_BYTES   = 90;

	// Directed row kinds: checked by predictor, typed with no result, typed result
	localparam int ROW_PRED  = 0;
	localparam int ROW_NONE  = 1;
	localparam int ROW_FIXED = 2;

	typedef struct packed {
		gtl_pkg::kind_t kind;
		logic [15:0]    x;
		logic [15:0]    y;
		logic [6:0]     code;
		logic [23:0]    addr;
		logic           blank;
	} glyph_res_t;

	typedef struct {
		logic [7:0] b;
		logic       f;
		int         chk;
		glyph_res_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gtl_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] text_byte;
	logic first_of_string;
	logic out_valid;
	logic out_stall;
	logic [1:0] result_kind;
	logic [gtl_pkg::COORD_FIELD_W-1:0] pos_x;
	logic [gtl_pkg::COORD_FIELD_W-1:0] pos_y;
	logic [6:0] ascii_code;
	logic [gtl_pkg::ADDR_FIELD_W-1:0] glyph_address;
	logic blank_glyph;

	gbk_text_layout_engine_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.text_byte       (text_byte),
		.first_of_string (first_of_string),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.ascii_code      (ascii_code),
		.glyph_address   (glyph_address),
		.blank_glyph     (blank_glyph)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow registers and layout state
	logic [15:0] org_x = 16'd0;
	logic [15:0] org_y = 16'd0;
	logic [15:0] area_w = gtl_pkg::AREA_WIDTH_RST;
	logic [15:0] area_h = gtl_pkg::AREA_HEIGHT_RST;
	logic [1:0]  font_sel = gtl_pkg::FONT_SIZE_RST;
	logic [23:0] g_base = 24'd0;
	logic [15:0] cur_x = 16'd0;
	logic [15:0] cur_y = 16'd0;
	logic        lead_pend = 1'b0;
	logic [7:0]  lead_b = 8'd0;
	logic        halted = 1'b1;

	glyph_res_t expected_draws[$];
	dir_row_t   dir_rows[$];
	int mismatches = 0;
	int sent_bytes = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int quiet_cycles = 0;

	function automatic int glyph_px(input logic [1:0] sel);
		unique case (sel)
			gtl_pkg::FONT_12: return 12;
			gtl_pkg::FONT_16: return 16;
			default: return 24;
		endcase
	endfunction

	// Wrap to the next line if the glyph does not fit, then report a clip
	function automatic bit wrap_clip(input int gw, input int px);
		longint cx, cy, ox, oy, aw, ah;
		cx = cur_x;
		ox = org_x;
		aw = area_w;
		if (cx > ox + aw - gw) begin
			cur_y = cur_y + 16'(px);
			cur_x = org_x;
		end
		cy = cur_y;
		oy = org_y;
		ah = area_h;
		return cy > oy + ah - px;
	endfunction

	// Advance the layout by one byte; returns 1 when a result is produced
	function automatic bit layout_step(input logic [7:0] b, input logic f,
			output glyph_res_t r);
		int px, gbytes, lidx, slot;
		longint a;
		logic [7:0] hi;
		r = '0;
		px = glyph_px(font_sel);
		if (f) begin
			cur_x = org_x;
			cur_y = org_y;
			halted = 1'b0;
			lead_pend = 1'b0;
			lead_b = 8'd0;
		end
		if (halted)
			return 1'b0;
		r.x = cur_x;
		r.y = cur_y;
		if (b == gtl_pkg::BYTE_NUL) begin
			lead_pend = 1'b0;
			lead_b = 8'd0;
			halted = 1'b1;
			r.kind = gtl_pkg::KIND_END;
			return 1'b1;
		end
		if (lead_pend) begin
			hi = lead_b;
			lead_pend = 1'b0;
			lead_b = 8'd0;
			if (wrap_clip(px, px)) begin
				halted = 1'b1;
				r.kind = gtl_pkg::KIND_CLIP;
				r.x = cur_x;
				r.y = cur_y;
				return 1'b1;
			end
			r.kind = gtl_pkg::KIND_WIDE;
			r.x = cur_x;
			r.y = cur_y;
			if (hi < gtl_pkg::LEAD_MIN || b < gtl_pkg::TRAIL_MIN ||
				b == gtl_pkg::CODE_INVALID || hi == gtl_pkg::CODE_INVALID) begin
				r.blank = 1'b1;
			end else begin
				gbytes = (px == 12) ? 24 : (px == 16) ? 32 : 72;
				// trail 0x7F is a hole in the table, skip it
				lidx = (b < gtl_pkg::TRAIL_GAP) ? int'(b) - int'(gtl_pkg::TRAIL_MIN)
					: int'(b) - int'(gtl_pkg::TRAIL_SHIFT);
				slot = int'(gtl_pkg::ROW_CODES) * (int'(hi) - int'(gtl_pkg::LEAD_MIN)) + lidx;
				a = longint'(slot) * gbytes + longint'(g_base);
				r.addr = a[23:0];
			end
			cur_x = cur_x + 16'(px);
			return 1'b1;
		end
		if (b > gtl_pkg::ASCII_TOP) begin
			lead_pend = 1'b1;
			lead_b = b;
			return 1'b0;
		end
		if (wrap_clip(px / 2, px)) begin
			halted = 1'b1;
			r.kind = gtl_pkg::KIND_CLIP;
			r.x = cur_x;
			r.y = cur_y;
			return 1'b1;
		end
		if (b == gtl_pkg::BYTE_LF || b == gtl_pkg::BYTE_CR) begin
			cur_y = cur_y + 16'(px);
			cur_x = org_x;
			return 1'b0;
		end
		r.kind = gtl_pkg::KIND_ASCII;
		r.x = cur_x;
		r.y = cur_y;
		r.code = b[6:0];
		cur_x = cur_x + 16'(px / 2);
		return 1'b1;
	endfunction

	function automatic dir_row_t row(input logic [7:0] b, input logic f, input int chk,
			input gtl_pkg::kind_t kind, input int x, input int y, input int code,
			input int addr, input logic blank);
		dir_row_t d;
		d.b = b;
		d.f = f;
		d.chk = chk;
		d.r.kind = kind;
		d.r.x = 16'(x);
		d.r.y = 16'(y);
		d.r.code = 7'(code);
		d.r.addr = 24'(addr);
		d.r.blank = blank;
		return d;
	endfunction

	task automatic flag_error(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	// Offer one byte, wait for it to be taken, then predict its result
	task automatic send_req(input logic [7:0] b, input logic f, input int chk = ROW_PRED,
			input glyph_res_t fixed = '0);
		glyph_res_t r;
		bit has;
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		first_of_string <= f;
		do @(posedge clk); while (in_stall);
		sent_bytes++;
		has = layout_step(b, f, r);
		if (chk == ROW_NONE) begin
			has = 1'b0;
		end else if (chk == ROW_FIXED) begin
			has = 1'b1;
			r = fixed;
		end
		if (has)
			expected_draws.push_back(r);
	endtask

	// Hold the input until every expected result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gtl_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			gtl_pkg::REG_ORIGIN_X:    org_x = val[15:0];
			gtl_pkg::REG_ORIGIN_Y:    org_y = val[15:0];
			gtl_pkg::REG_AREA_WIDTH:  area_w = val[15:0];
			gtl_pkg::REG_AREA_HEIGHT: area_h = val[15:0];
			gtl_pkg::REG_FONT_SIZE:   font_sel = val[1:0];
			gtl_pkg::REG_GLYPH_BASE:  g_base = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [15:0] any_extent();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 400));
	endfunction

	// Register setting of each phase: fixed corners first, then random
	task automatic setup_phase(input int p);
		logic [15:0] ox, oy, w, h;
		logic [1:0] fs;
		logic [23:0] base;
		ox = 16'($urandom_range(0, 200));
		oy = 16'($urandom_range(0, 200));
		w = any_extent();
		h = any_extent();
		fs = 2'($urandom_range(0, 3));
		base = 24'($urandom);
		unique case (p)
			0: begin
				ox = 16'd0; oy = 16'd0; w = 16'd240; h = 16'd320;
				fs = gtl_pkg::FONT_12; base = 24'd0;
			end
			1: begin
				ox = 16'd100; oy = 16'd40; w = 16'd200; h = 16'd120;
				fs = gtl_pkg::FONT_24; base = 24'hFFFFFF;
			end
			2: begin
				// selector above the table falls back to the largest font
				ox = 16'hFFFF; oy = 16'hFFFF; w = 16'hFFFF; h = 16'hFFFF; fs = 2'd3;
			end
			3: begin
				ox = 16'd0; oy = 16'd0; w = 16'd0; h = 16'd0;
				fs = gtl_pkg::FONT_16; base = 24'd0;
			end
			4: begin
				w = 16'($urandom_range(12, 100));
				h = 16'($urandom_range(12, 100));
			end
			5: begin ox = 16'($urandom); oy = 16'($urandom); w = 16'hFFFF; h = 16'd60; end
			default: begin
				if ($urandom_range(0, 3) == 0) ox = 16'($urandom);
				if ($urandom_range(0, 3) == 0) oy = 16'($urandom);
			end
		endcase
		write_reg(gtl_pkg::REG_ORIGIN_X, {8'd0, ox});
		write_reg(gtl_pkg::REG_ORIGIN_Y, {8'd0, oy});
		write_reg(gtl_pkg::REG_AREA_WIDTH, {8'd0, w});
		write_reg(gtl_pkg::REG_AREA_HEIGHT, {8'd0, h});
		write_reg(gtl_pkg::REG_FONT_SIZE, {22'd0, fs});
		write_reg(gtl_pkg::REG_GLYPH_BASE, base);
		cfg_wr_en <= 1'b0;
	endtask

	// One string: opening byte, mixed ASCII, newlines and GBK pairs, mostly a terminator
	task automatic send_string();
		int len, pick;
		logic [7:0] lead;
		logic [7:0] trail;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 24);
		if ($urandom_range(0, 9) == 0)
			send_req(8'($urandom_range(0, 255)), 1'b1);
		else
			send_req(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
		for (int k = 0; k < len; k++) begin
			// after a clip the rest of the string is ignored
			if (halted && $urandom_range(0, 3) != 0)
				break;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_req(8'($urandom_range(1, 128)), 1'b0);
			end else if (pick < 63) begin
				send_req(($urandom_range(0, 1) != 0) ? gtl_pkg::BYTE_LF : gtl_pkg::BYTE_CR,
					1'b0);
			end else begin
				lead = 8'($urandom_range(8'h81, 8'hFF));
				if ($urandom_range(0, 99) < 85)
					trail = 8'($urandom_range(8'h40, 8'hFE));
				else
					trail = 8'($urandom_range(0, 255));
				send_req(lead, 1'b0);
				send_req(trail, 1'b0);
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_req(gtl_pkg::BYTE_NUL, 1'b0);
	endtask

	// Broken input: random bytes, now and then an unexpected string start
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			send_req(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
	endtask

	// Receiver: random stall, or a long counted hold when requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Result check against the oldest expected draw
	always @(posedge clk) begin
		glyph_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_draws.size() == 0) begin
				flag_error("result with no request pending, kind", result_kind, -1);
			end else begin
				want = expected_draws.pop_front();
				if (result_kind !== want.kind)
					flag_error("result_kind", result_kind, want.kind);
				if (pos_x !== want.x)
					flag_error("pos_x", pos_x, want.x);
				if (pos_y !== want.y)
					flag_error("pos_y", pos_y, want.y);
				if (ascii_code !== want.code)
					flag_error("ascii_code", ascii_code, want.code);
				if (glyph_address !== want.addr)
					flag_error("glyph_address", glyph_address, want.addr);
				if (blank_glyph !== want.blank)
					flag_error("blank_glyph", blank_glyph, want.blank);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit held, paused;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		text_byte = 8'd0;
		first_of_string = 1'b0;

		// Directed rows at the reset setting: 16 px font, 240 x 320 area at 0,0
		dir_rows.push_back(row(8'h41, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h41, 1'b1, ROW_FIXED, gtl_pkg::KIND_ASCII, 0, 0, 8'h41, 0,
			1'b0));
		dir_rows.push_back(row(8'h7F, 1'b0, ROW_FIXED, gtl_pkg::KIND_ASCII, 8, 0, 8'h7F, 0,
			1'b0));
		dir_rows.push_back(row(8'h80, 1'b0, ROW_FIXED, gtl_pkg::KIND_ASCII, 16, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h01, 1'b0, ROW_PRED, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(gtl_pkg::BYTE_LF, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0,
			1'b0));
		dir_rows.push_back(row(8'h81, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h40, 1'b0, ROW_FIXED, gtl_pkg::KIND_WIDE, 0, 16, 0, 0, 1'b0));
		dir_rows.push_back(row(8'hFE, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'hFE, 1'b0, ROW_FIXED, gtl_pkg::KIND_WIDE, 16, 16, 0, 24'hBB060,
			1'b0));
		dir_rows.push_back(row(8'h81, 1'b0, ROW_PRED, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h7F, 1'b0, ROW_PRED, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'hA0, 1'b0, ROW_PRED, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h3F, 1'b0, ROW_FIXED, gtl_pkg::KIND_WIDE, 48, 16, 0, 0, 1'b1));
		dir_rows.push_back(row(8'hFF, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h80, 1'b0, ROW_FIXED, gtl_pkg::KIND_WIDE, 64, 16, 0, 0, 1'b1));
		dir_rows.push_back(row(8'h81, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'hFF, 1'b0, ROW_FIXED, gtl_pkg::KIND_WIDE, 80, 16, 0, 0, 1'b1));
		dir_rows.push_back(row(gtl_pkg::BYTE_CR, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0,
			1'b0));
		dir_rows.push_back(row(8'hB0, 1'b0, ROW_PRED, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(gtl_pkg::BYTE_NUL, 1'b0, ROW_FIXED, gtl_pkg::KIND_END, 0, 32, 0, 0,
			1'b0));
		dir_rows.push_back(row(8'h41, 1'b0, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(gtl_pkg::BYTE_NUL, 1'b1, ROW_FIXED, gtl_pkg::KIND_END, 0, 0, 0, 0,
			1'b0));
		dir_rows.push_back(row(8'hC8, 1'b1, ROW_NONE, gtl_pkg::KIND_ASCII, 0, 0, 0, 0, 1'b0));
		dir_rows.push_back(row(8'h5A, 1'b1, ROW_FIXED, gtl_pkg::KIND_ASCII, 0, 0, 8'h5A, 0,
			1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].b, dir_rows[i].f, dir_rows[i].chk, dir_rows[i].r);

		held = 1'b0;
		paused = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			send_gap_pct = 0;
			stall_pct = 0;
			setup_phase(p);
			unique case (p % 4)
				1: send_gap_pct = 70;
				2: stall_pct = 70;
				3: begin send_gap_pct = 8; stall_pct = 8; end
				default: ;
			endcase
			sent_bytes = 0;
			while (sent_bytes < PHASE_BYTES) begin
				// back-pressure: long receiver hold while requests keep coming
				if (p == 4 && !held && sent_bytes >= 30) begin
					hold_req = LONG_HOLD;
					held = 1'b1;
				end
				if (p == 6 && !paused && sent_bytes >= 60) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 85)
					send_string();
				else
					send_noise();
			end
		end

		in_valid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gtl_pkg.sv
rtl/gtl_ctrl.sv
rtl/gtl_dp.sv
rtl/gbk_text_layout_engine_unit.sv
bench/gbk_text_layout_engine_unit_tb.sv
